@@ rtl/prq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_pkg
// Shared types and constants for the priority ready queue scheduler.
// ----------------------------------------------------------------------------
package prq_pkg;

  localparam int QUEUE_DEPTH = 8;

  localparam int PRIO_W  = 8;
  localparam int REM_W   = 8;
  localparam int ID_W    = 16;
  localparam int STAT_W  = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AGING_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_BUDGET      = 1'd1;

  localparam logic [PRIO_W-1:0] AGING_THRESHOLD_RST = 8'd5;
  localparam logic [REM_W-1:0]  RUN_BUDGET_RST      = 8'd5;

  // Request operations
  localparam logic OP_INSERT   = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STAT_W-1:0] ST_REQUEUED = 3'd1;
  localparam logic [STAT_W-1:0] ST_RETIRED  = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic              op;
    logic [PRIO_W-1:0] priority_req;
    logic [ID_W-1:0]   task_id;
  } in_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   served_id;
    logic [PRIO_W-1:0] new_priority;
  } out_res_t;

  // Controller to datapath
  typedef struct packed {
    logic load_req;  // latch accepted request
    logic exec;      // run request and write result register
    logic place;     // reinsert the aged head task
  } prq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic op;
    logic empty;
    logic retire;
    logic out_free;
  } prq_sts_t;

endpackage

@@ rtl/prq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_ctrl
// Sequencer: accept, execute, optional requeue placement.
// ----------------------------------------------------------------------------
module prq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  prq_pkg::prq_sts_t sts_i,
  output prq_pkg::prq_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_PLACE
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   requeue;

  assign requeue = (sts_i.op == prq_pkg::OP_DISPATCH) && !sts_i.empty && !sts_i.retire;

  assign in_ready_o     = in_ready_q;
  assign cmd_o.load_req = in_valid_i && in_ready_q;
  assign cmd_o.exec     = (state_q == S_EXEC) && sts_i.out_free;
  assign cmd_o.place    = (state_q == S_PLACE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      in_ready_q <= 1'b1;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_q) begin
            state_q    <= S_EXEC;
            in_ready_q <= 1'b0;
          end
        end
        S_EXEC: begin
          // hold until the result register can take the result
          if (sts_i.out_free) begin
            if (requeue) begin
              state_q <= S_PLACE;
            end else begin
              state_q    <= S_IDLE;
              in_ready_q <= 1'b1;
            end
          end
        end
        S_PLACE: begin
          state_q    <= S_IDLE;
          in_ready_q <= 1'b1;
        end
        default: begin
          state_q    <= S_IDLE;
          in_ready_q <= 1'b1;
        end
      endcase
    end
  end

endmodule

@@ rtl/prq_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_datapath
// Sorted shifting entry array, aging unit, config and result registers.
// ----------------------------------------------------------------------------
module prq_datapath #(
  parameter int QUEUE_DEPTH = prq_pkg::QUEUE_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  prq_pkg::in_req_t                 in_req_i,
  input  logic                             cfg_we_i,
  input  logic [prq_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [prq_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output prq_pkg::out_res_t                out_res_o,
  input  prq_pkg::prq_cmd_t                cmd_i,
  output prq_pkg::prq_sts_t                sts_o
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [prq_pkg::PRIO_W-1:0] prio_q [QUEUE_DEPTH];
  logic [prq_pkg::PRIO_W-1:0] prio_d [QUEUE_DEPTH];
  logic [prq_pkg::REM_W-1:0]  rem_q  [QUEUE_DEPTH];
  logic [prq_pkg::REM_W-1:0]  rem_d  [QUEUE_DEPTH];
  logic [prq_pkg::ID_W-1:0]   id_q   [QUEUE_DEPTH];
  logic [prq_pkg::ID_W-1:0]   id_d   [QUEUE_DEPTH];
  logic [CNT_W-1:0]           occ_q, occ_d;

  logic                       req_op_q, req_op_d;
  logic [prq_pkg::PRIO_W-1:0] req_prio_q, req_prio_d;
  logic [prq_pkg::REM_W-1:0]  req_rem_q, req_rem_d;
  logic [prq_pkg::ID_W-1:0]   req_id_q, req_id_d;

  logic [prq_pkg::PRIO_W-1:0] thr_q;
  logic [prq_pkg::REM_W-1:0]  budget_q;

  logic              out_valid_q, out_valid_d;
  prq_pkg::out_res_t out_res_q, out_res_d;

  logic [QUEUE_DEPTH-1:0]     lt;
  logic [prq_pkg::PRIO_W:0]   dbl;
  logic [prq_pkg::PRIO_W-1:0] aged;
  logic                       full, empty, do_place;

  assign full  = (occ_q == CNT_W'(QUEUE_DEPTH));
  assign empty = (occ_q == '0);

  // Valid entries below the new priority; sorted, so this is a thermometer.
  always_comb begin
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      lt[k] = (CNT_W'(k) < occ_q) && (prio_q[k] < req_prio_q);
    end
  end

  // Aging of the head priority, saturating at the top
  assign dbl = {prio_q[0], 1'b0};
  always_comb begin
    if (prio_q[0] > thr_q) begin
      aged = (prio_q[0] == '1) ? '1 : prio_q[0] + 1'b1;
    end else begin
      aged = dbl[prq_pkg::PRIO_W] ? '1 : dbl[prq_pkg::PRIO_W-1:0];
    end
  end

  assign do_place = cmd_i.place ||
                    (cmd_i.exec && (req_op_q == prq_pkg::OP_INSERT) && !full);

  always_comb begin
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      prio_d[k] = prio_q[k];
      rem_d[k]  = rem_q[k];
      id_d[k]   = id_q[k];
    end
    occ_d       = occ_q;
    req_op_d    = req_op_q;
    req_prio_d  = req_prio_q;
    req_rem_d   = req_rem_q;
    req_id_d    = req_id_q;
    out_res_d   = out_res_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (cmd_i.load_req) begin
      req_op_d   = in_req_i.op;
      req_prio_d = in_req_i.priority_req;
      req_rem_d  = budget_q;
      req_id_d   = in_req_i.task_id;
    end

    if (do_place) begin
      // keep entries ahead, drop the new one at the boundary, shift the rest up
      if (!lt[0]) begin
        prio_d[0] = req_prio_q;
        rem_d[0]  = req_rem_q;
        id_d[0]   = req_id_q;
      end
      for (int k = 1; k < QUEUE_DEPTH; k++) begin
        if (!lt[k]) begin
          if (lt[k-1]) begin
            prio_d[k] = req_prio_q;
            rem_d[k]  = req_rem_q;
            id_d[k]   = req_id_q;
          end else begin
            prio_d[k] = prio_q[k-1];
            rem_d[k]  = rem_q[k-1];
            id_d[k]   = id_q[k-1];
          end
        end
      end
      occ_d = occ_q + 1'b1;
    end

    if (cmd_i.exec) begin
      out_valid_d            = 1'b1;
      out_res_d.served_id    = '0;
      out_res_d.new_priority = '0;
      if (req_op_q == prq_pkg::OP_INSERT) begin
        out_res_d.status = full ? prq_pkg::ST_FULL : prq_pkg::ST_INSERTED;
      end else if (empty) begin
        out_res_d.status = prq_pkg::ST_EMPTY;
      end else begin
        out_res_d.served_id    = id_q[0];
        out_res_d.new_priority = aged;
        out_res_d.status = (rem_q[0] == '0) ? prq_pkg::ST_RETIRED : prq_pkg::ST_REQUEUED;
        // pop the head
        for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
          prio_d[k] = prio_q[k+1];
          rem_d[k]  = rem_q[k+1];
          id_d[k]   = id_q[k+1];
        end
        occ_d = occ_q - 1'b1;
        // the head comes back as the pending request for the place step
        req_prio_d = aged;
        req_rem_d  = rem_q[0] - 1'b1;
        req_id_d   = id_q[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      out_valid_q <= 1'b0;
      thr_q       <= prq_pkg::AGING_THRESHOLD_RST;
      budget_q    <= prq_pkg::RUN_BUDGET_RST;
    end else begin
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          prq_pkg::REG_AGING_THRESHOLD: thr_q    <= cfg_data_i;
          prq_pkg::REG_RUN_BUDGET:      budget_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      prio_q[k] <= prio_d[k];
      rem_q[k]  <= rem_d[k];
      id_q[k]   <= id_d[k];
    end
    req_op_q   <= req_op_d;
    req_prio_q <= req_prio_d;
    req_rem_q  <= req_rem_d;
    req_id_q   <= req_id_d;
    out_res_q  <= out_res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  assign sts_o.op       = req_op_q;
  assign sts_o.empty    = empty;
  assign sts_o.retire   = (rem_q[0] == '0);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule

@@ rtl/priority_ready_queue_scheduler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler
// Sorted ready queue with insert, dispatch, aging and requeue.
// ----------------------------------------------------------------------------
//  channel   signals                         dir
//  request   in_valid_i in_ready_o in_req_i  in
//  result    out_valid_o out_ready_i out_res_o out
//  config    cfg_we_i cfg_idx_i cfg_data_i   in
//
// Insert, retire and empty/full requests pass through accept and execute;
// a requeued dispatch adds a place step that puts the aged task back
// into the shifting entry array. Requests are handled one at a time.
// Reset clears occupancy, result valid and config; entries need no clearing.
// A stalled result holds the execute step until the result register frees.
// ----------------------------------------------------------------------------
module priority_ready_queue_scheduler #(
  parameter int QUEUE_DEPTH = prq_pkg::QUEUE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  prq_pkg::in_req_t               in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output prq_pkg::out_res_t              out_res_o,
  input  logic                           cfg_we_i,
  input  logic [prq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [prq_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  prq_pkg::prq_cmd_t cmd;
  prq_pkg::prq_sts_t sts;

  prq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  prq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
